>>> rtl/cta_pkg.sv
// Shared constants, widths and helper functions for the complementary tilt filter.
`default_nettype none
package cta_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_DEPTH        = 24;
  localparam int ATAN_IDX_W        = $clog2(ATAN_DEPTH);

  localparam int IN_W      = 16;
  localparam int ANGLE_W   = 17;
  localparam int ALPHA_W   = 17;
  localparam int CORDIC_W  = 28;   // CORDIC x/y datapath
  localparam int Z_W       = 26;   // CORDIC angle accumulator, 1/65536 degree
  localparam int SUMSQ_W   = 32;
  localparam int SQ_W      = 48;
  localparam int ROOT_W    = 24;
  localparam int ROOT_CNT_W = $clog2(ROOT_W);

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int PRED_W  = ANGLE_W + 1;

  localparam int ANGLE_LIMIT = 46080;
  localparam int ALPHA_ONE   = 65536;
  localparam int ALPHA_RESET = 64225;
  localparam int GYRO_K      = 61521;
  localparam int Z90         = 5898240;

  // Rounded atan(2^-i) in 1/65536 degree.
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:  v = Z_W'(2949120);
      5'd1:  v = Z_W'(1740967);
      5'd2:  v = Z_W'(919879);
      5'd3:  v = Z_W'(466945);
      5'd4:  v = Z_W'(234378);
      5'd5:  v = Z_W'(117304);
      5'd6:  v = Z_W'(58666);
      5'd7:  v = Z_W'(29335);
      5'd8:  v = Z_W'(14668);
      5'd9:  v = Z_W'(7334);
      5'd10: v = Z_W'(3667);
      5'd11: v = Z_W'(1834);
      5'd12: v = Z_W'(917);
      5'd13: v = Z_W'(458);
      5'd14: v = Z_W'(229);
      5'd15: v = Z_W'(115);
      5'd16: v = Z_W'(57);
      5'd17: v = Z_W'(29);
      5'd18: v = Z_W'(14);
      5'd19: v = Z_W'(7);
      5'd20: v = Z_W'(4);
      5'd21: v = Z_W'(2);
      5'd22: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Clamp to +-180 degrees in 1/256 degree.
  function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [39:0] v);
    logic signed [ANGLE_W-1:0] r;
    if (v > 40'sd46080) begin
      r = ANGLE_W'(ANGLE_LIMIT);
    end else if (v < -40'sd46080) begin
      r = -ANGLE_W'(ANGLE_LIMIT);
    end else begin
      r = ANGLE_W'(v);
    end
    return r;
  endfunction

  // Round a Q16 blend sum to the angle grid and clamp.
  function automatic logic signed [ANGLE_W-1:0] blend_round(
      input logic signed [MUL_P_W-1:0] s);
    logic signed [MUL_P_W-1:0] r;
    r = s + MUL_P_W'(32768);
    return sat_angle(40'(signed'(r[MUL_P_W-1:16])));
  endfunction

endpackage
`default_nettype wire

>>> rtl/complementary_tilt_filter_top.sv
// Complementary roll/pitch tilt filter: sequencer, state and blend around shared units.
//
// One IMU sample is taken per request when in_stall is low. The accelerometer roll
// angle comes from a CORDIC pass that runs beside a 24-step square root of
// 65536*(y^2+z^2); the pitch CORDIC pass reuses the same unit once the root is ready.
// A single 33x18 multiplier does the squares, both gyro increments and the alpha blend.
// An item passes from accept to result through the squares, the gyro products and
// the wait on the 24-step root, the pitch pass (which gives zero without iterating
// when both pitch operands are zero), the blend and the output load. A new request
// is taken only once the sequencer is back in idle after the output load, so a
// sample is not accepted while the last one is in progress. The root unit and the
// serial pitch pass set the time per sample. The result sits in its own register,
// so the next sample is taken while it waits on out_stall. Writes to alpha_gain
// (Q0.16, values above 65536 act as 1.0) belong between items.
`default_nettype none
module complementary_tilt_filter_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [cta_pkg::ALPHA_W-1:0]          cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [cta_pkg::IN_W-1:0]      accel_x,
  input  logic signed [cta_pkg::IN_W-1:0]      accel_y,
  input  logic signed [cta_pkg::IN_W-1:0]      accel_z,
  input  logic signed [cta_pkg::IN_W-1:0]      gyro_x,
  input  logic signed [cta_pkg::IN_W-1:0]      gyro_y,
  input  logic [cta_pkg::IN_W-1:0]             dt_us,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cta_pkg::ANGLE_W-1:0]   roll_out,
  output logic signed [cta_pkg::ANGLE_W-1:0]   pitch_out
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SQR   = 7'b0000010,
    ST_GYRO  = 7'b0000100,
    ST_WAIT  = 7'b0001000,
    ST_PITCH = 7'b0010000,
    ST_BLEND = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [2:0] step;

  logic [cta_pkg::ALPHA_W-1:0] alpha_gain;
  logic [cta_pkg::ALPHA_W-1:0] alpha_c;
  logic [cta_pkg::ALPHA_W-1:0] alpha_inv;

  logic signed [cta_pkg::IN_W-1:0] ax;
  logic signed [cta_pkg::IN_W-1:0] ay;
  logic signed [cta_pkg::IN_W-1:0] az;
  logic signed [cta_pkg::IN_W-1:0] gx;
  logic signed [cta_pkg::IN_W-1:0] gy;
  logic [cta_pkg::IN_W-1:0]        dt;

  logic signed [cta_pkg::ANGLE_W-1:0] roll_angle;
  logic signed [cta_pkg::ANGLE_W-1:0] pitch_angle;
  logic signed [cta_pkg::ANGLE_W-1:0] accel_roll;
  logic signed [cta_pkg::PRED_W-1:0]  pred_roll;
  logic signed [cta_pkg::PRED_W-1:0]  pred_pitch;
  logic [cta_pkg::SUMSQ_W-1:0]        sumsq;
  logic signed [cta_pkg::MUL_P_W-1:0] blend_sum;

  logic signed [cta_pkg::MUL_A_W-1:0] mul_a;
  logic signed [cta_pkg::MUL_B_W-1:0] mul_b;
  logic signed [cta_pkg::MUL_P_W-1:0] mul_p;

  logic signed [cta_pkg::MUL_P_W-1:0] inc_sum;
  logic signed [cta_pkg::ANGLE_W-1:0] gyro_inc;
  logic signed [cta_pkg::MUL_P_W-1:0] blend_total;
  logic signed [cta_pkg::ANGLE_W-1:0] blend_angle;

  logic [cta_pkg::SUMSQ_W-1:0]         sumsq_next;
  logic                                sqrt_start;
  logic                                sqrt_busy;
  logic [cta_pkg::ROOT_W-1:0]          root;
  logic                                cordic_start;
  logic                                cordic_busy;
  logic signed [cta_pkg::CORDIC_W-1:0] cordic_yv;
  logic signed [cta_pkg::CORDIC_W-1:0] cordic_xv;
  logic signed [cta_pkg::ANGLE_W-1:0]  cordic_angle;
  logic signed [cta_pkg::CORDIC_W-1:0] ax_wide;
  logic                                units_done;
  logic                                out_load;

  assign in_stall = (state != ST_IDLE);

  // alpha above 1.0 acts as pure gyro integration
  assign alpha_c   = (alpha_gain > cta_pkg::ALPHA_W'(cta_pkg::ALPHA_ONE)) ?
                     cta_pkg::ALPHA_W'(cta_pkg::ALPHA_ONE) : alpha_gain;
  assign alpha_inv = cta_pkg::ALPHA_W'(cta_pkg::ALPHA_ONE) - alpha_c;

  assign sumsq_next = sumsq + mul_p[cta_pkg::SUMSQ_W-1:0];

  assign inc_sum  = mul_p + (cta_pkg::MUL_P_W'(1) <<< 31);
  assign gyro_inc = inc_sum[cta_pkg::ANGLE_W+31:32];

  assign blend_total = blend_sum + mul_p;
  assign blend_angle = cta_pkg::blend_round(blend_total);

  assign units_done = !sqrt_busy && !cordic_busy;
  assign out_load   = (state == ST_OUT) && (!out_valid || !out_stall);

  assign sqrt_start   = (state == ST_SQR) && (step == 3'd2);
  assign cordic_start = sqrt_start || ((state == ST_WAIT) && units_done);

  assign ax_wide = cta_pkg::CORDIC_W'(ax);

  always_comb begin
    if (state == ST_WAIT) begin
      cordic_yv = -(ax_wide <<< 8);
      cordic_xv = cta_pkg::CORDIC_W'(root);
    end else begin
      cordic_yv = cta_pkg::CORDIC_W'(ay) <<< 8;
      cordic_xv = cta_pkg::CORDIC_W'(az) <<< 8;
    end
  end

  // multiplier operand schedule
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQR: begin
        if (step == 3'd0) begin
          mul_a = cta_pkg::MUL_A_W'(ay);
          mul_b = cta_pkg::MUL_B_W'(ay);
        end else begin
          mul_a = cta_pkg::MUL_A_W'(az);
          mul_b = cta_pkg::MUL_B_W'(az);
        end
      end
      ST_GYRO: begin
        case (step)
          3'd0: begin
            mul_a = cta_pkg::MUL_A_W'(gx);
            mul_b = {2'b00, dt};
          end
          3'd2: begin
            mul_a = cta_pkg::MUL_A_W'(gy);
            mul_b = {2'b00, dt};
          end
          default: begin
            mul_a = mul_p[cta_pkg::MUL_A_W-1:0];
            mul_b = cta_pkg::MUL_B_W'(cta_pkg::GYRO_K);
          end
        endcase
      end
      ST_BLEND: begin
        case (step)
          3'd0: begin
            mul_a = cta_pkg::MUL_A_W'(pred_roll);
            mul_b = {1'b0, alpha_c};
          end
          3'd1: begin
            mul_a = cta_pkg::MUL_A_W'(accel_roll);
            mul_b = {1'b0, alpha_inv};
          end
          3'd2: begin
            mul_a = cta_pkg::MUL_A_W'(pred_pitch);
            mul_b = {1'b0, alpha_c};
          end
          default: begin
            mul_a = cta_pkg::MUL_A_W'(cordic_angle);
            mul_b = {1'b0, alpha_inv};
          end
        endcase
      end
      default: ;
    endcase
  end

  cta_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  cta_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .n     ({sumsq_next, 16'b0}),
    .busy  (sqrt_busy),
    .root  (root)
  );

  cta_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .yv    (cordic_yv),
    .xv    (cordic_xv),
    .busy  (cordic_busy),
    .angle (cordic_angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain <= cta_pkg::ALPHA_W'(cta_pkg::ALPHA_RESET);
    end else if (cfg_wr_en) begin
      alpha_gain <= cfg_wr_data;
    end
  end

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      roll_angle  <= '0;
      pitch_angle <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          step <= '0;
          if (in_valid) begin
            state <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (step == 3'd2) begin
            step  <= '0;
            state <= ST_GYRO;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_GYRO: begin
          if (step == 3'd4) begin
            step  <= '0;
            state <= ST_WAIT;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_WAIT: begin
          if (units_done) begin
            state <= ST_PITCH;
          end
        end
        ST_PITCH: begin
          if (!cordic_busy) begin
            step  <= '0;
            state <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          if (step == 3'd2) begin
            roll_angle <= blend_angle;
          end
          if (step == 3'd4) begin
            pitch_angle <= blend_angle;
            step        <= '0;
            state       <= ST_OUT;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath holding registers
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && in_valid) begin
      ax <= accel_x;
      ay <= accel_y;
      az <= accel_z;
      gx <= gyro_x;
      gy <= gyro_y;
      dt <= dt_us;
    end
    if ((state == ST_SQR) && (step == 3'd1)) begin
      sumsq <= mul_p[cta_pkg::SUMSQ_W-1:0];
    end
    if ((state == ST_GYRO) && (step == 3'd2)) begin
      pred_roll <= cta_pkg::PRED_W'(roll_angle) + cta_pkg::PRED_W'(gyro_inc);
    end
    if ((state == ST_GYRO) && (step == 3'd4)) begin
      pred_pitch <= cta_pkg::PRED_W'(pitch_angle) + cta_pkg::PRED_W'(gyro_inc);
    end
    if ((state == ST_WAIT) && units_done) begin
      accel_roll <= cordic_angle;
    end
    if ((state == ST_BLEND) && ((step == 3'd1) || (step == 3'd3))) begin
      blend_sum <= mul_p;
    end
    if (out_load) begin
      roll_out  <= roll_angle;
      pitch_out <= pitch_angle;
    end
  end

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("result raised outside the output load state");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    (sqrt_busy || cordic_busy) |->
      (state == ST_GYRO || state == ST_WAIT || state == ST_PITCH))
    else $error("shared unit busy outside its sequencer window");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |->
      (roll_angle <= 17'sd46080 && roll_angle >= -17'sd46080 &&
       pitch_angle <= 17'sd46080 && pitch_angle >= -17'sd46080))
    else $error("stored angle beyond 180 degrees");

endmodule
`default_nettype wire

>>> rtl/cta_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none
module cta_mul (
  input  logic                                 clk,
  input  logic signed [cta_pkg::MUL_A_W-1:0]   a,
  input  logic signed [cta_pkg::MUL_B_W-1:0]   b,
  output logic signed [cta_pkg::MUL_P_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= cta_pkg::MUL_P_W'(a) * cta_pkg::MUL_P_W'(b);
  end

endmodule
`default_nettype wire

>>> rtl/cta_isqrt.sv
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module cta_isqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [cta_pkg::SQ_W-1:0]        n,
  output logic                            busy,
  output logic [cta_pkg::ROOT_W-1:0]      root
);

  logic [cta_pkg::SQ_W-1:0]       rem;
  logic [cta_pkg::SQ_W-1:0]       res;
  logic [cta_pkg::SQ_W-1:0]       bitpos;
  logic [cta_pkg::ROOT_CNT_W-1:0] cnt;
  logic [cta_pkg::SQ_W-1:0]       trial;
  logic                           last;

  assign trial = res + bitpos;
  assign last  = (cnt == cta_pkg::ROOT_CNT_W'(cta_pkg::ROOT_W - 1));
  assign root  = res[cta_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= n;
      res    <= '0;
      bitpos <= cta_pkg::SQ_W'(1) << (cta_pkg::SQ_W - 2);
      cnt    <= '0;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitpos;
      end else begin
        res <= res >> 1;
      end
      bitpos <= bitpos >> 2;
      cnt    <= cnt + 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cta_cordic.sv
// Iterative vectoring CORDIC giving atan2(y, x) in 1/256 degree.
`default_nettype none
module cta_cordic (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [cta_pkg::CORDIC_W-1:0]   yv,
  input  logic signed [cta_pkg::CORDIC_W-1:0]   xv,
  output logic                                  busy,
  output logic signed [cta_pkg::ANGLE_W-1:0]    angle
);

  logic signed [cta_pkg::CORDIC_W-1:0] x;
  logic signed [cta_pkg::CORDIC_W-1:0] y;
  logic signed [cta_pkg::Z_W-1:0]      z;
  logic [cta_pkg::ATAN_IDX_W-1:0]      idx;

  logic signed [cta_pkg::CORDIC_W-1:0] dx;
  logic signed [cta_pkg::CORDIC_W-1:0] dy;
  logic signed [cta_pkg::CORDIC_W-1:0] x_next;
  logic signed [cta_pkg::CORDIC_W-1:0] y_next;
  logic signed [cta_pkg::Z_W-1:0]      z_next;
  logic signed [cta_pkg::Z_W-1:0]      z_rnd;
  logic signed [cta_pkg::Z_W-1:0]      atan_step;
  logic                                last;
  logic                                zero_in;

  assign dx        = y >>> idx;
  assign dy        = x >>> idx;
  assign atan_step = cta_pkg::atan_lut(idx);
  assign last      = (idx == cta_pkg::ATAN_IDX_W'(cta_pkg::CORDIC_ITERATIONS - 1));
  assign zero_in   = (xv == '0) && (yv == '0);

  always_comb begin
    if (y > 0) begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + atan_step;
    end else begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - atan_step;
    end
  end

  assign z_rnd = z_next + cta_pkg::Z_W'(128);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= !zero_in;
    end else if (busy && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx <= '0;
      if (zero_in) begin
        angle <= '0;
      end
      // pre-rotate left half plane vectors by a quarter turn
      if (xv < 0) begin
        if (yv >= 0) begin
          x <= yv;
          y <= -xv;
          z <= cta_pkg::Z_W'(cta_pkg::Z90);
        end else begin
          x <= -yv;
          y <= xv;
          z <= -cta_pkg::Z_W'(cta_pkg::Z90);
        end
      end else begin
        x <= xv;
        y <= yv;
        z <= '0;
      end
    end else if (busy) begin
      x   <= x_next;
      y   <= y_next;
      z   <= z_next;
      idx <= idx + 1'b1;
      if (last) begin
        angle <= cta_pkg::sat_angle(40'(signed'(z_rnd[cta_pkg::Z_W-1:8])));
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_complementary_tilt_filter_top.sv
// Self-checking testbench for the complementary roll/pitch tilt filter top level.
`timescale 1ns / 1ps
module tb_complementary_tilt_filter_top;
  import cta_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 120;
  localparam int REPORT_MAX = 10;
  localparam int HOLD_CYCLES = 500;

  typedef struct {
    logic signed [IN_W-1:0] accel_x;
    logic signed [IN_W-1:0] accel_y;
    logic signed [IN_W-1:0] accel_z;
    logic signed [IN_W-1:0] gyro_x;
    logic signed [IN_W-1:0] gyro_y;
    logic [IN_W-1:0]        dt_us;
  } imu_sample_t;

  typedef struct {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
  } tilt_angles_t;

  // atan(2^-i) in 1/65536 degree
  localparam longint ATAN_STEP [24] = '{
    2949120, 1740967, 919879, 466945, 234378, 117304, 58666, 29335,
    14668, 7334, 3667, 1834, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [ALPHA_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [IN_W-1:0] accel_x = '0;
  logic signed [IN_W-1:0] accel_y = '0;
  logic signed [IN_W-1:0] accel_z = '0;
  logic signed [IN_W-1:0] gyro_x = '0;
  logic signed [IN_W-1:0] gyro_y = '0;
  logic [IN_W-1:0] dt_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ANGLE_W-1:0] roll_out;
  logic signed [ANGLE_W-1:0] pitch_out;

  tilt_angles_t pending_angles[$];
  longint tilt_roll = 0;
  longint tilt_pitch = 0;
  longint alpha_reg = ALPHA_RESET;

  int fail_count = 0;
  int cycle_count = 0;
  int in_idle_pct = 33;
  int out_stall_pct = 33;
  int hold_left = 0;

  complementary_tilt_filter_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .accel_x    (accel_x),
    .accel_y    (accel_y),
    .accel_z    (accel_z),
    .gyro_x     (gyro_x),
    .gyro_y     (gyro_y),
    .dt_us      (dt_us),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .roll_out   (roll_out),
    .pitch_out  (pitch_out)
  );

  always #1 clk = ~clk;

  function automatic longint clamp_angle(input longint v);
    if (v > ANGLE_LIMIT) return ANGLE_LIMIT;
    if (v < -ANGLE_LIMIT) return -ANGLE_LIMIT;
    return v;
  endfunction

  function automatic longint root_floor(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  // Vectoring atan2 in 1/256 degree.
  function automatic longint vector_angle(input longint yv, input longint xv);
    longint x, y, z, t, dx, dy;
    x = xv;
    y = yv;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // pre-rotate left half-plane by -+90 degrees
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = Z90;
      end else begin
        x = -y;
        y = t;
        z = -Z90;
      end
    end
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_STEP[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_STEP[i];
      end
    end
    return clamp_angle((z + 128) >>> 8);
  endfunction

  function automatic longint gyro_increment(input longint rate, input longint dt);
    return (rate * dt * GYRO_K + (longint'(1) << 31)) >>> 32;
  endfunction

  function automatic longint blend_angle(input longint pred, input longint acc,
                                         input longint a);
    return clamp_angle((a * pred + (ALPHA_ONE - a) * acc + 32768) >>> 16);
  endfunction

  // Advance the filter state by one sample and queue the angles it must produce.
  task automatic predict_tilt(input imu_sample_t s);
    longint ax, ay, az, gx, gy, dt, a, root, accel_roll, accel_pitch;
    tilt_angles_t exp_angles;
    ax = s.accel_x;
    ay = s.accel_y;
    az = s.accel_z;
    gx = s.gyro_x;
    gy = s.gyro_y;
    dt = s.dt_us;
    a = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    root = root_floor(longint'(ay * ay + az * az) * 65536);
    accel_roll = vector_angle(ay * 256, az * 256);
    accel_pitch = vector_angle(-ax * 256, root);
    tilt_roll = blend_angle(tilt_roll + gyro_increment(gx, dt), accel_roll, a);
    tilt_pitch = blend_angle(tilt_pitch + gyro_increment(gy, dt), accel_pitch, a);
    exp_angles.roll = ANGLE_W'(tilt_roll);
    exp_angles.pitch = ANGLE_W'(tilt_pitch);
    pending_angles.push_back(exp_angles);
  endtask

  // Offer one request after a random gap; return at the edge that accepts it.
  task automatic send_sample(input imu_sample_t s);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= s.accel_x;
    accel_y <= s.accel_y;
    accel_z <= s.accel_z;
    gyro_x <= s.gyro_x;
    gyro_y <= s.gyro_y;
    dt_us <= s.dt_us;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tilt(s);
  endtask

  task automatic send_fields(input int ax, input int ay, input int az,
                             input int gx, input int gy, input int dt);
    imu_sample_t s;
    s.accel_x = IN_W'(ax);
    s.accel_y = IN_W'(ay);
    s.accel_z = IN_W'(az);
    s.gyro_x = IN_W'(gx);
    s.gyro_y = IN_W'(gy);
    s.dt_us = IN_W'(dt);
    send_sample(s);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
  endtask

  task automatic write_alpha(input logic [ALPHA_W-1:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    alpha_reg = value;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    if ($urandom_range(99) < 65) begin
      // plausible sensor: gravity-sized accel, modest rates
      s.accel_x = IN_W'(int'($urandom_range(40000)) - 20000);
      s.accel_y = IN_W'(int'($urandom_range(40000)) - 20000);
      s.accel_z = IN_W'(int'($urandom_range(40000)) - 20000);
      s.gyro_x = IN_W'(int'($urandom_range(8000)) - 4000);
      s.gyro_y = IN_W'(int'($urandom_range(8000)) - 4000);
      s.dt_us = IN_W'($urandom_range(20000, 200));
    end else begin
      s.accel_x = IN_W'($urandom());
      s.accel_y = IN_W'($urandom());
      s.accel_z = IN_W'($urandom());
      s.gyro_x = IN_W'($urandom());
      s.gyro_y = IN_W'($urandom());
      s.dt_us = IN_W'($urandom());
    end
    return s;
  endfunction

  // Receiver: random stall, or a counted hold-off when requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    tilt_angles_t exp_angles;
    if (!rst && out_valid && !out_stall) begin
      if (pending_angles.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result: roll=%0d pitch=%0d", roll_out, pitch_out);
      end else begin
        exp_angles = pending_angles.pop_front();
        if (roll_out !== exp_angles.roll || pitch_out !== exp_angles.pitch) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("mismatch: roll exp=%0d act=%0d, pitch exp=%0d act=%0d",
                     exp_angles.roll, roll_out, exp_angles.pitch, pitch_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed_samples();
    send_fields(0, 0, 0, 0, 0, 0);
    send_fields(0, 0, 16384, 0, 0, 1000);
    send_fields(32767, 32767, 32767, 32767, 32767, 65535);
    send_fields(-32768, -32768, -32768, -32768, -32768, 65535);
    // roll operands both zero, pitch straight up
    send_fields(-32768, 0, 0, 0, 0, 0);
    // left half-plane on the roll vector, both signs of y
    send_fields(0, 16384, -16384, 100, -100, 2000);
    send_fields(0, -16384, -16384, -100, 100, 2000);
    send_fields(0, 0, -16384, 0, 0, 500);
    send_fields(0, -32768, 0, 0, 0, 500);
    send_fields(16384, 0, 0, 0, 0, 500);
    send_fields(5, -3, 1, 7, -7, 3);
    send_fields(100, 200, 300, 32767, -32768, 0);
    send_fields(0, 0, 0, 32767, -32768, 65535);
    send_fields(-1, -1, -1, -1, -1, 1);
  endtask

  task automatic test_alpha_extremes();
    // pure gyro: run both angles into the +-180 degree clamp
    write_alpha(ALPHA_W'(ALPHA_ONE));
    send_fields(0, 0, 16384, 32767, 32767, 65535);
    send_fields(0, 0, 16384, 32767, 32767, 65535);
    send_fields(0, 0, 16384, -32768, -32768, 65535);
    send_fields(0, 0, 16384, -32768, -32768, 65535);
    send_fields(0, 0, 16384, -32768, -32768, 65535);
    // above 1.0 acts as 1.0
    write_alpha({ALPHA_W{1'b1}});
    send_fields(1000, -2000, 3000, 32767, 12345, 65535);
    send_fields(-1000, 2000, -3000, -32768, -12345, 40000);
    // pure accelerometer
    write_alpha('0);
    send_fields(12000, -9000, 8000, 32767, -32768, 65535);
    send_fields(-20000, 15000, -10000, 0, 0, 0);
  endtask

  task automatic test_output_backpressure();
    write_alpha(ALPHA_W'(ALPHA_RESET));
    in_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (15) send_sample(random_sample());
    in_idle_pct = 33;
  endtask

  task automatic test_random_samples();
    logic [ALPHA_W-1:0] phase_alpha [6];
    phase_alpha[0] = ALPHA_W'(ALPHA_RESET);
    phase_alpha[1] = ALPHA_W'($urandom_range(ALPHA_ONE));
    phase_alpha[2] = '0;
    phase_alpha[3] = ALPHA_W'($urandom_range(ALPHA_ONE, 60000));
    phase_alpha[4] = ALPHA_W'(ALPHA_ONE);
    phase_alpha[5] = ALPHA_W'($urandom_range({ALPHA_W{1'b1}}, ALPHA_ONE + 1));
    for (int p = 0; p < 6; p++) begin
      write_alpha(phase_alpha[p]);
      // one phase runs back to back on both sides
      in_idle_pct = (p == 3) ? 0 : 33;
      out_stall_pct = (p == 3) ? 0 : 33;
      repeat (140) send_sample(random_sample());
    end
    in_idle_pct = 33;
    out_stall_pct = 33;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_samples();
    test_alpha_extremes();
    test_output_backpressure();
    test_random_samples();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_angles.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> complementary_tilt_filter_top.f
rtl/cta_pkg.sv
rtl/cta_mul.sv
rtl/cta_isqrt.sv
rtl/cta_cordic.sv
rtl/complementary_tilt_filter_top.sv
tb/tb_complementary_tilt_filter_top.sv
